// ===== rtl/core/tws_pkg.sv =====
package tws_pkg;

	// Fixed field widths
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned ADDR_W   = 12;
	localparam int unsigned COLOR_W  = 24;
	localparam int unsigned X_W      = 12;
	localparam int unsigned Y_W      = 12;
	localparam int unsigned THICK_W  = 16;
	localparam int unsigned TCOL_W   = 6;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned STORE_DEPTH = 1 << ADDR_W;

	// Input item commands
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_PIXEL = 2'd2
	} tws_cmd_code_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 1'd1;

	// Pixel color source
	typedef enum logic [1:0] {
		SEL_CEIL  = 2'd0,
		SEL_TEX   = 2'd1,
		SEL_FLOOR = 2'd2
	} tws_sel_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [ADDR_W-1:0]  texel_addr;
		logic [COLOR_W-1:0] texel_color;
		logic [X_W-1:0]     screen_x;
		logic [THICK_W-1:0] thickness;
		logic [TCOL_W-1:0]  tex_column;
	} tws_in_t;

	typedef struct packed {
		logic [X_W-1:0]     pixel_x;
		logic [Y_W-1:0]     pixel_y;
		logic [COLOR_W-1:0] color;
		logic               last;
	} tws_out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_texel;
		logic start_col;
		logic div_step;
		logic mul_go;
		logic ofs_go;
		logic pixel_go;
		logic out_load;
	} tws_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
		logic col_active;
	} tws_stat_t;

endpackage

// ===== rtl/core/tws_if.sv =====
// Input item channel
interface tws_in_if;
	logic             valid;
	logic             ready;
	tws_pkg::tws_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result item channel
interface tws_out_if;
	logic              valid;
	logic              ready;
	tws_pkg::tws_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tws_ctrl.sv =====
module tws_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [tws_pkg::CMD_W-1:0]  in_cmd,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  tws_pkg::tws_stat_t         stat,
	output tws_pkg::tws_ctl_t          ctl
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DIV   = 5'b00010,
		S_MUL   = 5'b00100,
		S_OFS   = 5'b01000,
		S_FETCH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_fire;

	// Accept only when idle and the output register is free or draining
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					priority if (in_cmd == tws_pkg::CMD_LOAD) begin
						ctl.load_texel = 1'b1;
					end else if (in_cmd == tws_pkg::CMD_START) begin
						ctl.start_col = 1'b1;
						state_d       = S_DIV;
					end else if (in_cmd == tws_pkg::CMD_PIXEL && stat.col_active) begin
						ctl.pixel_go = 1'b1;
						state_d      = S_FETCH;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				ctl.mul_go = 1'b1;
				state_d    = S_OFS;
			end
			S_OFS: begin
				ctl.ofs_go = 1'b1;
				state_d    = S_IDLE;
			end
			S_FETCH: begin
				ctl.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output item valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/tws_dpath.sv =====
module tws_dpath #(
	parameter int unsigned SCREEN_HEIGHT = 512,
	parameter int unsigned TEXTURE_SIZE  = 64,
	parameter int unsigned FRAC_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tws_pkg::tws_ctl_t             ctl,
	input  tws_pkg::tws_in_t              in_data,
	input  logic                          cfg_we,
	input  logic [tws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tws_pkg::COLOR_W-1:0]   cfg_data,
	output tws_pkg::tws_stat_t            stat,
	output tws_pkg::tws_out_t             out_data
);

	localparam int unsigned LIMIT   = TEXTURE_SIZE << FRAC_BITS;
	localparam int unsigned STEP_W  = $clog2(LIMIT + 1);
	localparam int unsigned ACC_W   = STEP_W + 1;
	localparam int unsigned PROD_W  = tws_pkg::THICK_W + STEP_W;
	localparam int unsigned REM_W   = tws_pkg::THICK_W + 1;
	localparam int unsigned DCNT_W  = $clog2(STEP_W);
	localparam int unsigned RC_W    = $clog2(SCREEN_HEIGHT + 1);
	localparam int unsigned ROW_W   = $clog2(TEXTURE_SIZE);
	localparam int unsigned BOUND_W = tws_pkg::THICK_W + 1;

	localparam logic [ACC_W-1:0]           LIMIT_A = ACC_W'(LIMIT);
	localparam logic [BOUND_W-1:0]         H_B     = BOUND_W'(SCREEN_HEIGHT);
	localparam logic [RC_W-1:0]            H_R     = RC_W'(SCREEN_HEIGHT);
	localparam logic [RC_W-1:0]            H_LAST  = RC_W'(SCREEN_HEIGHT - 1);
	localparam logic [tws_pkg::ADDR_W-1:0] TS_A    = tws_pkg::ADDR_W'(TEXTURE_SIZE);
	localparam logic [DCNT_W-1:0]          DIV_LAST = DCNT_W'(STEP_W - 1);

	// Configuration registers
	logic [tws_pkg::COLOR_W-1:0] ceil_color_q, floor_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_color_q  <= '0;
			floor_color_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tws_pkg::CFG_CEILING: ceil_color_q  <= cfg_data;
				tws_pkg::CFG_FLOOR:   floor_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Column parameters latched at start
	logic [tws_pkg::X_W-1:0]     col_idx_q;
	logic [tws_pkg::THICK_W-1:0] thick_q;
	logic [tws_pkg::TCOL_W-1:0]  tcol_q;
	logic                        clip_q;
	logic [RC_W-1:0]             ceil_end_q;
	logic [BOUND_W-1:0]          wall_end_q;
	logic [BOUND_W-1:0]          thick_b;

	assign thick_b = {1'b0, in_data.thickness};

	always_ff @(posedge clk) begin
		if (ctl.start_col) begin
			col_idx_q  <= in_data.screen_x;
			thick_q    <= in_data.thickness;
			tcol_q     <= in_data.tex_column;
			clip_q     <= (thick_b >= H_B);
			ceil_end_q <= (thick_b < H_B) ? RC_W'((H_B - thick_b) >> 1) : '0;
			wall_end_q <= BOUND_W'((H_B + thick_b) >> 1);
		end
	end

	// Restoring divider, one quotient bit per cycle
	logic [STEP_W-1:0]           quot_q;
	logic [tws_pkg::THICK_W-1:0] rem_q;
	logic [DCNT_W-1:0]           dcnt_q;
	logic [REM_W-1:0]            rem_sh;
	logic                        q_bit;

	assign rem_sh = {rem_q, quot_q[STEP_W-1]};
	assign q_bit  = (rem_sh >= {1'b0, thick_q});

	always_ff @(posedge clk) begin
		if (ctl.start_col) begin
			quot_q <= STEP_W'(LIMIT);
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (ctl.div_step) begin
			rem_q  <= q_bit ? tws_pkg::THICK_W'(rem_sh - {1'b0, thick_q})
				: rem_sh[tws_pkg::THICK_W-1:0];
			quot_q <= {quot_q[STEP_W-2:0], q_bit};
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	assign stat.div_done = (dcnt_q == DIV_LAST);

	// Step and clipped-part offset product
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [PROD_W-1:0] prod_q;

	assign step_d = (thick_q == '0) ? '0 : quot_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_go) begin
			step_q <= step_d;
			prod_q <= PROD_W'(tws_pkg::THICK_W'(thick_q - tws_pkg::THICK_W'(SCREEN_HEIGHT)))
				* PROD_W'(step_d);
		end
	end

	// Texture row accumulator
	logic [ACC_W-1:0] acc_q;
	logic             tex_in;

	assign tex_in = (acc_q < LIMIT_A);

	// Row counter; SCREEN_HEIGHT means no active column
	logic [RC_W-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= H_R;
		end else if (ctl.start_col) begin
			row_q <= '0;
		end else if (ctl.pixel_go) begin
			row_q <= row_q + 1'b1;
		end
	end

	assign stat.col_active = (row_q < H_R);

	// Pixel source choice
	tws_pkg::tws_sel_t sel_d;

	always_comb begin
		priority if (row_q < ceil_end_q) begin
			sel_d = tws_pkg::SEL_CEIL;
		end else if ((BOUND_W'(row_q) < wall_end_q) && tex_in) begin
			sel_d = tws_pkg::SEL_TEX;
		end else begin
			sel_d = tws_pkg::SEL_FLOOR;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ofs_go) begin
			acc_q <= clip_q ? ACC_W'(prod_q >> 1) : '0;
		end else if (ctl.pixel_go && sel_d == tws_pkg::SEL_TEX) begin
			acc_q <= acc_q + ACC_W'(step_q);
		end
	end

	// Texture store with registered read
	logic [tws_pkg::COLOR_W-1:0] store_mem [tws_pkg::STORE_DEPTH];
	logic [tws_pkg::COLOR_W-1:0] rd_data_q;
	logic [tws_pkg::ADDR_W-1:0]  rd_addr;
	logic [ROW_W-1:0]            tex_row;

	assign tex_row = acc_q[FRAC_BITS +: ROW_W];
	assign rd_addr = tws_pkg::ADDR_W'(tex_row) * TS_A + tws_pkg::ADDR_W'(tcol_q);

	always_ff @(posedge clk) begin
		if (ctl.load_texel) begin
			store_mem[in_data.texel_addr] <= in_data.texel_color;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pixel_go) begin
			rd_data_q <= store_mem[rd_addr];
		end
	end

	// Pixel stage between accept and output
	tws_pkg::tws_sel_t sel_s1;
	logic [RC_W-1:0]   y_s1;
	logic              last_s1;

	always_ff @(posedge clk) begin
		if (ctl.pixel_go) begin
			sel_s1  <= sel_d;
			y_s1    <= row_q;
			last_s1 <= (row_q == H_LAST);
		end
	end

	// Output register
	tws_pkg::tws_out_t out_q;
	logic [tws_pkg::COLOR_W-1:0] color_d;

	always_comb begin
		unique case (sel_s1)
			tws_pkg::SEL_CEIL:  color_d = ceil_color_q;
			tws_pkg::SEL_TEX:   color_d = rd_data_q;
			tws_pkg::SEL_FLOOR: color_d = floor_color_q;
			default:            color_d = floor_color_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_q.pixel_x <= col_idx_q;
			out_q.pixel_y <= tws_pkg::Y_W'(y_s1);
			out_q.color   <= color_d;
			out_q.last    <= last_s1;
		end
	end

	assign out_data = out_q;

endmodule

// ===== rtl/core/textured_wall_column_shader.sv =====
// Load item: written to the store on accept. Pixel item: the accept registers
// the store read, then the fetch state loads the output register; the next
// item is taken once back in idle. Start item: the one-bit-per-cycle step divider
// makes STEP_W = clog2((TEXTURE_SIZE << FRAC_BITS) + 1) quotient bits (23 by
// default), then the multiply and offset states run. Reset clears control,
// both colors and leaves no column active; the texture store is not cleared.
module textured_wall_column_shader #(
	parameter int unsigned SCREEN_HEIGHT = 512,
	parameter int unsigned TEXTURE_SIZE  = 64,
	parameter int unsigned FRAC_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tws_pkg::COLOR_W-1:0]   cfg_data,
	tws_in_if.sink                        in_ch,
	tws_out_if.source                     out_ch
);

	tws_pkg::tws_ctl_t  ctl;
	tws_pkg::tws_stat_t stat;

	tws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_cmd    (in_ch.data.cmd),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	tws_dpath #(
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TEXTURE_SIZE  (TEXTURE_SIZE),
		.FRAC_BITS     (FRAC_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.in_data   (in_ch.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.out_data  (out_ch.data)
	);

endmodule
